// File: rtl/core/fcfs_process_scheduler_macros.svh
// Assertion macros used by the scheduler datapath.
`ifndef FCFS_PROCESS_SCHEDULER_MACROS_SVH
`define FCFS_PROCESS_SCHEDULER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define FCFS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define FCFS_ASSERT_IMPLIES(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define FCFS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/core/fcfs_pkg.sv
// Types and constants shared by the scheduler modules.
`timescale 1ns / 1ps

package fcfs_pkg;

    localparam int ID_W   = 8;
    localparam int SVC_W  = 16;
    localparam int TIME_W = 32;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_ZERO = 2'd2
    } status_t;

    // Input command codes.
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // One queued or running job.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SVC_W-1:0]  service;
        logic [TIME_W-1:0] arrival;
    } job_t;

    // One result record.
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   done_id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    push;
        logic    pop;
        logic    emit;
        status_t emit_status;
        logic    clear_busy;
        logic    advance;
    } fcfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic svc_zero;
        logic q_full;
        logic q_nonempty;
        logic busy;
        logic done_hit;
        logic out_free;
    } fcfs_stat_t;

endpackage

// File: rtl/core/fcfs_ifs.sv
// Handshake channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface fcfs_job_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [fcfs_pkg::ID_W-1:0]     job_id;
    logic [fcfs_pkg::SVC_W-1:0]    service_time;

    modport source (output valid, command, job_id, service_time, input ready);
    modport sink   (input valid, command, job_id, service_time, output ready);
endinterface

interface fcfs_result_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [fcfs_pkg::ID_W-1:0]     done_id;
    logic [fcfs_pkg::TIME_W-1:0]   start_time;
    logic [fcfs_pkg::TIME_W-1:0]   end_time;
    logic [fcfs_pkg::TIME_W-1:0]   waiting_time;
    logic [fcfs_pkg::TIME_W-1:0]   turnaround_time;

    modport source (output valid, status, done_id, start_time, end_time,
                    waiting_time, turnaround_time, input ready);
    modport sink   (input valid, status, done_id, start_time, end_time,
                    waiting_time, turnaround_time, output ready);
endinterface

// File: rtl/core/fcfs_ctrl.sv
// Controller state machine that sequences each arrival or tick item.
`timescale 1ns / 1ps

module fcfs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fcfs_pkg::fcfs_stat_t stat,
    output fcfs_pkg::fcfs_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   pop_needed;

    assign in_ready = in_ready_reg;

    // A queued job starts when nothing is left running after this tick.
    assign pop_needed = (!stat.busy || stat.done_hit) && stat.q_nonempty;

    // Next state and commands.
    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = fcfs_pkg::STAT_DONE;
        state_next      = state_reg;
        in_ready_next   = in_ready_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.capture   = 1'b1;
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                if (!stat.is_tick)
                begin
                    if (stat.svc_zero || stat.q_full)
                    begin
                        // Rejected arrival: wait for room in the output register.
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.svc_zero ? fcfs_pkg::STAT_ZERO
                                                            : fcfs_pkg::STAT_FULL;
                            state_next      = S_IDLE;
                            in_ready_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.push      = 1'b1;
                        state_next    = S_IDLE;
                        in_ready_next = 1'b1;
                    end
                end
                else if (!stat.done_hit || stat.out_free)
                begin
                    cmd.emit       = stat.done_hit;
                    cmd.clear_busy = stat.done_hit;
                    if (pop_needed)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        cmd.advance   = 1'b1;
                        state_next    = S_IDLE;
                        in_ready_next = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                cmd.pop       = 1'b1;
                cmd.advance   = 1'b1;
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

endmodule

// File: rtl/core/fcfs_datapath.sv
// Datapath: ready queue memory, running job, time counter and result register.
`timescale 1ns / 1ps
`include "fcfs_process_scheduler_macros.svh"

module fcfs_datapath #(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_command,
    input  logic [fcfs_pkg::ID_W-1:0]        in_job_id,
    input  logic [fcfs_pkg::SVC_W-1:0]       in_service_time,
    input  fcfs_pkg::fcfs_cmd_t              cmd,
    output fcfs_pkg::fcfs_stat_t             stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output fcfs_pkg::res_t                   out_res
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    fcfs_pkg::job_t                   queue_mem [QUEUE_DEPTH];
    fcfs_pkg::job_t                   rd_job_reg;

    logic                             cmd_reg;
    logic [fcfs_pkg::ID_W-1:0]        id_reg;
    logic [fcfs_pkg::SVC_W-1:0]       svc_reg;

    logic [PTR_W-1:0]                 head_reg;
    logic [PTR_W-1:0]                 tail_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [fcfs_pkg::TIME_W-1:0]      time_reg;
    logic                             busy_reg;
    fcfs_pkg::job_t                   run_job_reg;
    logic [fcfs_pkg::TIME_W-1:0]      run_start_reg;

    logic                             out_valid_reg;
    fcfs_pkg::res_t                   res_reg;
    fcfs_pkg::res_t                   res_next;

    logic [fcfs_pkg::TIME_W-1:0]      elapsed;
    logic [fcfs_pkg::TIME_W-1:0]      run_svc;
    logic [fcfs_pkg::TIME_W-1:0]      wait_time;
    logic                             q_full;
    logic                             out_free;

    // Status toward the controller.
    assign run_svc   = fcfs_pkg::TIME_W'(run_job_reg.service);
    assign elapsed   = time_reg - run_start_reg;
    assign q_full    = (count_reg == FULL_CNT);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.is_tick    = (cmd_reg == fcfs_pkg::CMD_TICK);
        stat.svc_zero   = (svc_reg == '0);
        stat.q_full     = q_full;
        stat.q_nonempty = (count_reg != '0);
        stat.busy       = busy_reg;
        stat.done_hit   = busy_reg && (elapsed == run_svc);
        stat.out_free   = out_free;
    end

    // Captured input item.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_command;
            id_reg  <= in_job_id;
            svc_reg <= in_service_time;
        end
    end

    // Ready queue memory: one write port, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            queue_mem[tail_reg] <= '{id: id_reg, service: svc_reg, arrival: time_reg};
        end
        rd_job_reg <= queue_mem[head_reg];
    end

    // Queue pointers, time and running job.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            time_reg      <= '0;
            busy_reg      <= 1'b0;
            run_job_reg   <= '0;
            run_start_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                tail_reg  <= (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.pop)
            begin
                head_reg      <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                count_reg     <= count_reg - 1'b1;
                run_job_reg   <= rd_job_reg;
                run_start_reg <= time_reg;
                busy_reg      <= 1'b1;
            end
            else if (cmd.clear_busy)
            begin
                busy_reg <= 1'b0;
            end
            if (cmd.advance)
            begin
                time_reg <= time_reg + 1'b1;
            end
        end
    end

    // Result record for a completion or a rejected arrival.
    assign wait_time = run_start_reg - run_job_reg.arrival;

    always_comb
    begin
        res_next.status = cmd.emit_status;
        if (cmd.emit_status == fcfs_pkg::STAT_DONE)
        begin
            res_next.done_id         = run_job_reg.id;
            res_next.start_time      = run_start_reg;
            res_next.end_time        = time_reg;
            res_next.waiting_time    = wait_time;
            res_next.turnaround_time = wait_time + run_svc;
        end
        else
        begin
            res_next.done_id         = id_reg;
            res_next.start_time      = '0;
            res_next.end_time        = '0;
            res_next.waiting_time    = '0;
            res_next.turnaround_time = '0;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Queue occupancy and sequencing checks.
    `FCFS_ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT, "queue count above depth")
    `FCFS_ASSERT_IMPLIES(a_push_not_full, cmd.push, !q_full, "push into a full queue")
    `FCFS_ASSERT_IMPLIES(a_pop_not_empty, cmd.pop, count_reg != '0, "pop from an empty queue")
    `FCFS_ASSERT_IMPLIES(a_emit_room, cmd.emit, out_free, "result overwrites a pending item")
    `FCFS_ASSERT_NEXT(a_pop_busy, cmd.pop, busy_reg, "started job is not running")

endmodule

// File: rtl/core/fcfs_process_scheduler.sv
// Top level of the first-come-first-served job scheduler.
// Usage: items enter on job_in (command 0 queues job_id with service_time at
// the current time, command 1 processes one time tick and then advances it).
// Results leave on result_out: a completion record (status 0) when a running
// job has served its full time, or a rejection (status 1 queue full, status 2
// zero service time) for an arrival that cannot be queued.
// Each item passes through the controller's idle and execute states, and a tick
// that starts a queued job also through its pop state, set by the controller
// sequence and the registered read port of the ready queue memory.
// A result is written into the output register from the controller's execute state.
// Reset (rst_n low, asynchronous) empties the queue, stops the running job and
// sets the time to zero; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the block keeps
// accepting items until a second result would be produced, then waits.
`timescale 1ns / 1ps

module fcfs_process_scheduler #(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    fcfs_job_if.sink        job_in,
    fcfs_result_if.source   result_out
);

    fcfs_pkg::fcfs_cmd_t  cmd;
    fcfs_pkg::fcfs_stat_t stat;
    fcfs_pkg::res_t       res;

    // Item sequencing.
    fcfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (job_in.valid),
        .in_ready (job_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Queue, timing and result storage.
    fcfs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_command      (job_in.command),
        .in_job_id       (job_in.job_id),
        .in_service_time (job_in.service_time),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (result_out.valid),
        .out_ready       (result_out.ready),
        .out_res         (res)
    );

    // Result payload onto the output channel.
    assign result_out.status          = res.status;
    assign result_out.done_id         = res.done_id;
    assign result_out.start_time      = res.start_time;
    assign result_out.end_time        = res.end_time;
    assign result_out.waiting_time    = res.waiting_time;
    assign result_out.turnaround_time = res.turnaround_time;

endmodule

// File: tb/sv/fcfs_process_scheduler_tb.sv
// Self-checking testbench for the first-come-first-served job scheduler.
`timescale 1ns / 1ps

module fcfs_process_scheduler_tb;

    import fcfs_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int QUIET_LIMIT = 5000;

    logic clk;
    logic rst_n;

    fcfs_job_if    job_ch ();
    fcfs_result_if res_ch ();

    fcfs_process_scheduler #(
        .QUEUE_DEPTH (QDEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_in     (job_ch),
        .result_out (res_ch)
    );

    // Scheduler shadow state kept by the predictor.
    job_t              waiting_jobs[$];
    job_t              run_job;
    logic              run_active;
    logic [TIME_W-1:0] run_start;
    logic [TIME_W-1:0] sched_time;

    // Records the scheduler is expected to emit, oldest first.
    res_t expected_records[$];
    res_t oldest;

    // Run control and bookkeeping.
    bit idle_enable;
    bit stall_enable;
    int ready_hold;
    int quiet_cycles;
    int items_sent;
    int records_seen;
    int done_seen;
    int rejects_seen;
    int mismatch_count;

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic res_t make_record(status_t st, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] t_start,
                                         logic [TIME_W-1:0] t_end,
                                         logic [TIME_W-1:0] t_wait,
                                         logic [TIME_W-1:0] t_turn);
        res_t r;
        r.status          = st;
        r.done_id         = id;
        r.start_time      = t_start;
        r.end_time        = t_end;
        r.waiting_time    = t_wait;
        r.turnaround_time = t_turn;
        return r;
    endfunction

    // Apply one accepted item to the shadow state and queue any record it causes.
    task automatic schedule_item(logic cmd, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
        job_t              fresh;
        logic [TIME_W-1:0] wait_t;
        if (cmd == CMD_ARRIVE)
        begin
            // Zero service is checked before a full queue.
            if (svc == '0)
                expected_records.push_back(make_record(STAT_ZERO, id, '0, '0, '0, '0));
            else if (waiting_jobs.size() >= QDEPTH)
                expected_records.push_back(make_record(STAT_FULL, id, '0, '0, '0, '0));
            else
            begin
                fresh.id      = id;
                fresh.service = svc;
                fresh.arrival = sched_time;
                waiting_jobs.push_back(fresh);
            end
        end
        else
        begin
            // A running job that has served its time completes first.
            if (run_active && (sched_time - run_start) == TIME_W'(run_job.service))
            begin
                wait_t     = run_start - run_job.arrival;
                run_active = 1'b0;
                expected_records.push_back(make_record(STAT_DONE, run_job.id, run_start,
                    sched_time, wait_t, wait_t + TIME_W'(run_job.service)));
            end
            // Then the oldest queued job starts if the processor is free.
            if (!run_active && waiting_jobs.size() > 0)
            begin
                run_job    = waiting_jobs.pop_front();
                run_start  = sched_time;
                run_active = 1'b1;
            end
            sched_time = sched_time + 1;
        end
    endtask

    // Send one item after an optional gap and wait for it to be taken.
    task automatic send_item(logic cmd, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
        int gap;
        gap = idle_enable ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            job_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        job_ch.valid        <= 1'b1;
        job_ch.command      <= cmd;
        job_ch.job_id       <= id;
        job_ch.service_time <= svc;
        @(posedge clk);
        while (!job_ch.ready)
            @(posedge clk);
        schedule_item(cmd, id, svc);
        items_sent++;
    endtask

    task automatic report_mismatch(string field, logic [TIME_W-1:0] got,
                                   logic [TIME_W-1:0] want);
        $display("mismatch in record %0d: %s is 0x%0h, expected 0x%0h",
                 records_seen, field, got, want);
        mismatch_count++;
    endtask

    // Result receiver: ready toggles in random runs when stalling is on.
    initial res_ch.ready = 1'b0;
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            if (!stall_enable || $urandom_range(0, 3) != 0)
            begin
                res_ch.ready <= 1'b1;
                ready_hold   <= $urandom_range(0, 6);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                ready_hold   <= pick_gap();
            end
        end
        else
            ready_hold <= ready_hold - 1;
    end

    // Compare every accepted record with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_records.size() == 0)
            begin
                report_mismatch("done_id of an unexpected record",
                                TIME_W'(res_ch.done_id), '0);
            end
            else
            begin
                oldest = expected_records.pop_front();
                if (res_ch.status != oldest.status)
                    report_mismatch("status", TIME_W'(res_ch.status), TIME_W'(oldest.status));
                if (res_ch.done_id != oldest.done_id)
                    report_mismatch("done_id", TIME_W'(res_ch.done_id), TIME_W'(oldest.done_id));
                if (res_ch.start_time != oldest.start_time)
                    report_mismatch("start_time", res_ch.start_time, oldest.start_time);
                if (res_ch.end_time != oldest.end_time)
                    report_mismatch("end_time", res_ch.end_time, oldest.end_time);
                if (res_ch.waiting_time != oldest.waiting_time)
                    report_mismatch("waiting_time", res_ch.waiting_time, oldest.waiting_time);
                if (res_ch.turnaround_time != oldest.turnaround_time)
                    report_mismatch("turnaround_time", res_ch.turnaround_time,
                                    oldest.turnaround_time);
                if (oldest.status == STAT_DONE)
                    done_seen++;
                else
                    rejects_seen++;
            end
            records_seen++;
        end
    end

    // Watchdog: too long without any item moving on either channel ends the run.
    always @(posedge clk)
    begin
        if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d records outstanding",
                     expected_records.size());
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Zero service time is rejected, at both ends of the id range.
    task automatic test_zero_service();
        send_item(CMD_ARRIVE, 8'h00, 16'h0000);
        send_item(CMD_ARRIVE, 8'hFF, 16'h0000);
    endtask

    // Fill the ready queue, then arrive once more with a full queue and once
    // with zero service into the full queue, where the zero check wins.
    task automatic test_queue_full();
        for (int i = 0; i < QDEPTH; i++)
            send_item(CMD_ARRIVE, ID_W'(i * 17), (i == 0) ? 16'd2 : SVC_W'((i % 3) + 1));
        send_item(CMD_ARRIVE, 8'hA5, 16'hFFFF);
        send_item(CMD_ARRIVE, 8'h5A, 16'h0000);
    endtask

    // First job completes; the next one starts after having waited.
    task automatic test_first_completion();
        repeat (3) send_item(CMD_TICK, 8'h00, 16'h0000);
        send_item(CMD_ARRIVE, 8'hFF, 16'd1);
        send_item(CMD_TICK, 8'hFF, 16'hFFFF);
    endtask

    // Random mix of arrivals and ticks with a given arrival share.
    task automatic test_random_mix(int n_items, int arrive_pct, int max_svc,
                                   bit idle_on, bit stall_on);
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] svc;
        int               r;
        idle_enable  = idle_on;
        stall_enable = stall_on;
        for (int i = 0; i < n_items; i++)
        begin
            id = ID_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < arrive_pct)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    svc = '0;
                else if (r < 20 && waiting_jobs.size() >= QDEPTH)
                    svc = SVC_W'($urandom_range(0, 65535));  // rejected anyway, so any size is safe
                else
                    svc = SVC_W'($urandom_range(1, max_svc));
                send_item(CMD_ARRIVE, id, svc);
            end
            else
            begin
                svc = SVC_W'($urandom_range(0, 65535));
                send_item(CMD_TICK, id, svc);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n               = 1'b0;
        job_ch.valid        = 1'b0;
        job_ch.command      = CMD_ARRIVE;
        job_ch.job_id       = '0;
        job_ch.service_time = '0;
        run_active          = 1'b0;
        run_job             = '0;
        run_start           = '0;
        sched_time          = '0;
        idle_enable         = 1'b1;
        stall_enable        = 1'b1;
        ready_hold          = 0;
        quiet_cycles        = 0;
        items_sent          = 0;
        records_seen        = 0;
        done_seen           = 0;
        rejects_seen        = 0;
        mismatch_count      = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_service();
        test_queue_full();
        test_first_completion();
        test_random_mix(300, 50, 4, 1'b1, 1'b1);
        test_random_mix(300, 75, 6, 1'b1, 1'b1);
        test_random_mix(250, 30, 3, 1'b0, 1'b0);
        test_random_mix(300, 55, 3, 1'b1, 1'b1);
        test_random_mix(250, 65, 10, 1'b1, 1'b0);
        test_random_mix(250, 40, 4, 1'b0, 1'b1);

        @(negedge clk);
        job_ch.valid <= 1'b0;

        // Let every outstanding record arrive, then a few quiet cycles.
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d items sent over %0d ticks; %0d records checked",
                 items_sent, sched_time, records_seen);
        $display("%0d completions and %0d rejected arrivals, %0d mismatches",
                 done_seen, rejects_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
